/* design/trace_region_span_merger_macros.svh */
// assertion macros used by the span merger checker
`ifndef TRACE_REGION_SPAN_MERGER_MACROS_SVH
`define TRACE_REGION_SPAN_MERGER_MACROS_SVH

// property checked outside reset
`define TRSM_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("span merger check failed");

// property checked on every edge, reset included
`define TRSM_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("span merger check failed");

`endif

/* design/trsm_pkg.sv */
// shared types and constants for the trace region span merger
`default_nettype none

package trsm_pkg;

   // event kinds
   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_BEGIN = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // csr register indexes
   localparam int unsigned CSR_ADDR_BITS = 1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_GAP_THRESHOLD = 1'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPAN_LIMIT    = 1'd1;

   localparam logic [15:0] SPAN_LIMIT_RESET = 16'hFFFF;
   localparam logic [15:0] COUNT_SAT        = 16'hFFFF;

   // one result item
   typedef struct packed {
      logic [15:0] span_label;
      logic [63:0] first_begin;
      logic [63:0] latest_end;
      logic [15:0] region_total;
      logic [7:0]  span_thread;
      logic [15:0] span_number;
      logic        last_of_run;
   } rsp_type;

endpackage

`default_nettype wire

/* design/trsm_if.sv */
// channel interfaces for events, spans and csr writes
`default_nettype none

interface trsm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [15:0] label_id;
   logic [63:0] timestamp;
   logic [7:0]  thread_num;
   logic        end_of_buffer;

   modport source (output valid, event_kind, label_id, timestamp, thread_num,
                   end_of_buffer, input ready);
   modport sink (input valid, event_kind, label_id, timestamp, thread_num,
                 end_of_buffer, output ready);
endinterface

interface trsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] span_label;
   logic [63:0] first_begin;
   logic [63:0] latest_end;
   logic [15:0] region_total;
   logic [7:0]  span_thread;
   logic [15:0] span_number;
   logic        last_of_run;

   modport source (output valid, span_label, first_begin, latest_end, region_total,
                   span_thread, span_number, last_of_run, input ready);
   modport sink (input valid, span_label, first_begin, latest_end, region_total,
                 span_thread, span_number, last_of_run, output ready);
endinterface

interface trsm_csr_if;
   logic                               valid;
   logic                               ready;
   logic [trsm_pkg::CSR_ADDR_BITS-1:0] addr;
   logic [63:0]                        wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

/* design/trace_region_span_merger.sv */
// Trace region span merger
// Usage: trace events enter on req_ch, one per transfer; merged spans leave on
// rsp_ch. An event may produce zero, one or two spans; last_of_run marks the
// final span produced by one event. gap_threshold (index 0) and the span limit
// (index 1) are written on csr_ch, which is always ready; write them only
// while no event is in flight.
// Path: an accepted event is held in the input register and evaluated there;
// its spans are written into the output queue, from which they transfer.
// Throughput: one event per cycle while the queue has room. The output queue
// drains one span per cycle while rsp_ready is high, and the queue (four
// entries) is what lets events keep flowing while two-span events drain.
// Stall: when rsp_ready is low the queue fills; the evaluate stage waits
// until two free entries are in sight, and req_ready stays low meanwhile.
// Reset: synchronous, active high; clears the open span, the per-buffer span
// count and the queue, sets gap_threshold to 0 and the span limit to 65535.
`default_nettype none

module trace_region_span_merger #(
   parameter int unsigned LABEL_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   trsm_req_if.sink     req_ch,
   trsm_rsp_if.source   rsp_ch,
   trsm_csr_if.sink     csr_ch
);

   localparam int unsigned KEEP_BITS  = (LABEL_BITS < 16) ? LABEL_BITS : 16;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_BITS   = $clog2(FIFO_DEPTH + 1);

   // configuration registers
   logic [63:0] gap_threshold_ff;
   logic [15:0] span_limit_ff;

   // input register
   logic                 in_valid_ff;
   logic [1:0]           in_kind_ff;
   logic [KEEP_BITS-1:0] in_label_ff;
   logic [63:0]          in_ts_ff;
   logic [7:0]           in_thread_ff;
   logic                 in_eob_ff;

   // span state
   logic                 open_ff,        open_in;
   logic [KEEP_BITS-1:0] open_label_ff,  open_label_in;
   logic [63:0]          open_first_ff,  open_first_in;
   logic [63:0]          open_last_ff,   open_last_in;
   logic [15:0]          open_regions_ff, open_regions_in;
   logic [7:0]           open_thread_ff, open_thread_in;
   logic [15:0]          spans_ff,       spans_in;

   // output queue
   trsm_pkg::rsp_type     fifo_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   // evaluate stage
   logic                 fire, pop;
   logic [CNT_BITS-1:0]  occ_after_pop;
   logic                 is_begin, is_end;
   logic [63:0]          gap_dist;
   logic                 split;
   logic [15:0]          spans_mid;
   logic                 merge;
   logic                 open_new;
   logic                 emit_a, emit_b;
   logic [1:0]           push_cnt;
   trsm_pkg::rsp_type    res_a, res_b, entry_a;

   // csr writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_threshold_ff <= '0;
         span_limit_ff    <= trsm_pkg::SPAN_LIMIT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.addr)
            trsm_pkg::CSR_GAP_THRESHOLD: gap_threshold_ff <= csr_ch.wdata;
            trsm_pkg::CSR_SPAN_LIMIT:    span_limit_ff    <= csr_ch.wdata[15:0];
            default: ;
         endcase
      end
   end

   // handshake and queue occupancy
   assign pop           = rsp_ch.valid && rsp_ch.ready;
   assign occ_after_pop = count_ff - CNT_BITS'(pop);
   assign fire          = in_valid_ff && (occ_after_pop <= CNT_BITS'(FIFO_DEPTH - 2));
   assign req_ch.ready  = !in_valid_ff || fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_kind_ff   <= req_ch.event_kind;
         in_label_ff  <= req_ch.label_id[KEEP_BITS-1:0];
         in_ts_ff     <= req_ch.timestamp;
         in_thread_ff <= req_ch.thread_num;
         in_eob_ff    <= req_ch.end_of_buffer;
      end
   end

   // split test and span update; kind three counts as an other event
   always_comb begin
      is_begin = (in_kind_ff == trsm_pkg::KIND_BEGIN);
      is_end   = (in_kind_ff == trsm_pkg::KIND_END);
      gap_dist = in_ts_ff - open_last_ff;
      split    = open_ff && ((in_label_ff != open_label_ff) ||
                             (is_begin && (gap_dist > gap_threshold_ff)));
      merge    = open_ff && !split;
      emit_a   = split;

      // closed span leaves first
      res_a.span_label   = 16'(open_label_ff);
      res_a.first_begin  = open_first_ff;
      res_a.latest_end   = open_last_ff;
      res_a.region_total = open_regions_ff;
      res_a.span_thread  = open_thread_ff;
      res_a.span_number  = spans_ff;

      spans_mid = (split && (spans_ff != trsm_pkg::COUNT_SAT)) ? spans_ff + 16'd1
                                                               : spans_ff;

      open_new = !merge && is_begin && (spans_mid < span_limit_ff);

      open_in         = merge || open_new;
      open_label_in   = open_label_ff;
      open_first_in   = open_first_ff;
      open_last_in    = open_last_ff;
      open_regions_in = open_regions_ff;
      open_thread_in  = open_thread_ff;
      if (merge) begin
         if (is_begin && (open_regions_ff != trsm_pkg::COUNT_SAT)) begin
            open_regions_in = open_regions_ff + 16'd1;
         end
         if (is_end) begin
            open_last_in = in_ts_ff;
         end
      end else if (open_new) begin
         open_label_in   = in_label_ff;
         open_first_in   = in_ts_ff;
         open_last_in    = in_ts_ff;
         open_regions_in = 16'd1;
         open_thread_in  = in_thread_ff;
      end

      // buffer end flushes whatever is open
      emit_b             = in_eob_ff && open_in;
      res_b.span_label   = 16'(open_label_in);
      res_b.first_begin  = open_first_in;
      res_b.latest_end   = open_last_in;
      res_b.region_total = open_regions_in;
      res_b.span_thread  = open_thread_in;
      res_b.span_number  = spans_mid;
      res_b.last_of_run  = 1'b1;
      res_a.last_of_run  = !emit_b;

      spans_in = spans_mid;
      if (in_eob_ff) begin
         spans_in = '0;
         open_in  = 1'b0;
      end

      entry_a  = emit_a ? res_a : res_b;
      push_cnt = fire ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
      count_in = occ_after_pop + CNT_BITS'(push_cnt);
   end

   // span state
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff         <= 1'b0;
         open_label_ff   <= '0;
         open_first_ff   <= '0;
         open_last_ff    <= '0;
         open_regions_ff <= '0;
         open_thread_ff  <= '0;
         spans_ff        <= '0;
      end else if (fire) begin
         open_ff         <= open_in;
         open_label_ff   <= open_label_in;
         open_first_ff   <= open_first_in;
         open_last_ff    <= open_last_in;
         open_regions_ff <= open_regions_in;
         open_thread_ff  <= open_thread_in;
         spans_ff        <= spans_in;
      end
   end

   // output queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(push_cnt);
         rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(pop);
         count_ff  <= count_in;
      end
   end

   // output queue storage, up to two writes per cycle
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= entry_a;
      end
      if (push_cnt == 2'd2) begin
         fifo_ff[wr_ptr_ff + PTR_BITS'(1)] <= res_b;
      end
   end

   // result channel
   assign rsp_ch.valid        = (count_ff != '0);
   assign rsp_ch.span_label   = fifo_ff[rd_ptr_ff].span_label;
   assign rsp_ch.first_begin  = fifo_ff[rd_ptr_ff].first_begin;
   assign rsp_ch.latest_end   = fifo_ff[rd_ptr_ff].latest_end;
   assign rsp_ch.region_total = fifo_ff[rd_ptr_ff].region_total;
   assign rsp_ch.span_thread  = fifo_ff[rd_ptr_ff].span_thread;
   assign rsp_ch.span_number  = fifo_ff[rd_ptr_ff].span_number;
   assign rsp_ch.last_of_run  = fifo_ff[rd_ptr_ff].last_of_run;

endmodule

`default_nettype wire

/* design/trsm_checker.sv */
// port-level checks for the trace region span merger, bound to the top level
`default_nettype none
`include "trace_region_span_merger_macros.svh"

module trsm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_span_number,
   input wire logic [15:0] rsp_region_total,
   input wire logic [63:0] rsp_first_begin
);

   // a stalled span holds until its transfer
   `TRSM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_span_number) && $stable(rsp_first_begin))

   // every span carries at least its opening region
   `TRSM_ASSERT(a_region_nonzero, clock, reset, rsp_valid |-> rsp_region_total != 16'd0)

   // reset empties the queue and the input register
   `TRSM_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)
   `TRSM_ASSERT_ALWAYS(a_reset_ready, clock, reset |=> req_ready)

endmodule

bind trace_region_span_merger trsm_checker u_trsm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_span_number  (rsp_ch.span_number),
   .rsp_region_total (rsp_ch.region_total),
   .rsp_first_begin  (rsp_ch.first_begin)
);

`default_nettype wire
